// ----- rtl/core/kal_pkg.sv -----
// Package for the keyed array list: field widths, operation and status codes,
// and the stored entry type. No dependencies.
`timescale 1ns / 1ps

package kal_pkg;

	localparam int KIND_W   = 3;
	localparam int KEY_W    = 32;
	localparam int PAY_W    = 64;
	localparam int IDX_W    = 5;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 5;

	localparam logic [CFG_W-1:0] MAX_RESET = CFG_W'(16);

	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

endpackage

// ----- rtl/core/kal_if.sv -----
// Valid/ready channel interfaces for the keyed array list request and response.
// Depends on kal_pkg.
`timescale 1ns / 1ps

interface kal_req_if;
	import kal_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       kind;
	logic signed [KEY_W-1:0] record_key;
	logic [IDX_W-1:0]        position;
	logic [PAY_W-1:0]        record_payload;

	modport source(output valid, kind, record_key, position, record_payload, input ready);
	modport sink(input valid, kind, record_key, position, record_payload, output ready);
endinterface

interface kal_rsp_if;
	import kal_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic signed [KEY_W-1:0] out_key;
	logic [PAY_W-1:0]        out_payload;
	logic [IDX_W-1:0]        out_index;
	logic [IDX_W-1:0]        entry_count;

	modport source(output valid, status, out_key, out_payload, out_index, entry_count,
		input ready);
	modport sink(input valid, status, out_key, out_payload, out_index, entry_count,
		output ready);
endinterface

// ----- rtl/core/kal_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kal_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/keyed_array_list.sv -----
// Top level of the keyed array list: sequencer, entry count and output register.
// Depends on kal_pkg, kal_req_if, kal_rsp_if and kal_ram.
//
//   Channel   Direction  Transfer               Contents
//   req       in         valid & ready          kind, record_key, position, record_payload
//   rsp       out        valid & ready          status, out_key, out_payload, out_index,
//                                               entry_count
//   cfg       in         cfg_we                 max_entries
//
// One RAM read port walks one entry per cycle. Append writes at the end; insert shifts
// entries up from the end to the position, then writes; lookup scans from entry 0 for the
// key; delete scans for the key, then shifts later entries down; a rejected op only answers.
// Reset clears the entry count and sets max_entries to 16; the store is not cleared.
// The result waits in an output register, so a new transaction is taken while
// a stalled response is held; the sequencer stalls only when its own result is blocked.
`timescale 1ns / 1ps

module keyed_array_list #(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [kal_pkg::CFG_W-1:0] cfg_wdata,
	kal_req_if.sink                   req,
	kal_rsp_if.source                 rsp
);
	import kal_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SRCH = 8'b0000_0010,
		S_SHDN = 8'b0000_0100,
		S_SHUP = 8'b0000_1000,
		S_WNEW = 8'b0001_0000,
		S_RDA  = 8'b0010_0000,
		S_RDB  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    max_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       rem_q;
	logic [AW-1:0]       la_q;
	logic [AW-1:0]       wpos_q;
	logic                rv_q;
	logic                ov_q;
	logic [KIND_W-1:0]   op_q;
	logic [KEY_W-1:0]    key_q;
	logic [PAY_W-1:0]    pay_q;
	logic [IDX_W-1:0]    pos_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [KEY_W-1:0]    res_key_q;
	logic [PAY_W-1:0]    res_pay_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [STATUS_W-1:0] o_status_q;
	logic [KEY_W-1:0]    o_key_q;
	logic [PAY_W-1:0]    o_pay_q;
	logic [IDX_W-1:0]    o_idx_q;
	logic [IDX_W-1:0]    o_cnt_q;

	logic [LW-1:0]       lim;
	logic [LW-1:0]       cnt_x;
	logic [LW-1:0]       pos_x;
	logic                accept;
	logic                full;
	logic                issue_up;
	logic                issue_fwd;
	logic                hit;
	logic                load_out;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	entry_t              ram_wdata;
	entry_t              ram_rdata;
	logic [STATUS_W-1:0] iss_status;
	logic [IDX_W-1:0]    iss_idx;
	logic [AW-1:0]       iss_wpos;
	logic [CW-1:0]       iss_ptr;
	logic [CW-1:0]       iss_rem;

	assign lim    = (LW'(max_q) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(max_q);
	assign cnt_x  = LW'(cnt_q);
	assign pos_x  = LW'(req.position);
	assign full   = cnt_x >= lim;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign issue_fwd = ptr_q < cnt_q;
	assign issue_up  = rem_q != '0;
	assign hit       = rv_q && (ram_rdata.key == key_q);
	assign load_out  = (state_q == S_DONE) && (!ov_q || rsp.ready);

	always_comb begin
		iss_status = ST_OK;
		iss_idx    = '0;
		iss_wpos   = cnt_q[AW-1:0];
		iss_ptr    = '0;
		iss_rem    = '0;
		unique case (req.kind)
			KIND_APPEND: begin
				if (full) begin
					iss_status = ST_FULL;
				end else begin
					iss_idx = IDX_W'(cnt_q);
				end
			end
			KIND_INSERT: begin
				if (full) begin
					iss_status = ST_FULL;
				end else if (pos_x > cnt_x) begin
					iss_status = ST_BADPOS;
				end else begin
					iss_idx  = req.position;
					iss_wpos = AW'(req.position);
					iss_ptr  = cnt_q - CW'(1);
					iss_rem  = CW'(cnt_x - pos_x);
				end
			end
			KIND_DELETE, KIND_LOOKUP: begin
				if (cnt_q == '0) begin
					iss_status = ST_NOTFOUND;
				end
			end
			KIND_READ: begin
				if (pos_x >= cnt_x) begin
					iss_status = ST_BADPOS;
				end else begin
					iss_ptr = CW'(req.position);
				end
			end
			default: begin
				iss_status = ST_OK;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = la_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_SHDN: begin
				ram_we    = rv_q;
				ram_waddr = la_q - AW'(1);
			end
			S_SHUP: begin
				ram_we    = rv_q;
				ram_waddr = la_q + AW'(1);
			end
			S_WNEW: begin
				ram_we    = 1'b1;
				ram_waddr = wpos_q;
				ram_wdata = '{key: key_q, payload: pay_q};
			end
			S_IDLE, S_SRCH, S_RDA, S_RDB, S_DONE: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	kal_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_q   <= MAX_RESET;
			cnt_q   <= '0;
			rv_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					rv_q <= 1'b0;
					if (accept) begin
						unique case (req.kind)
							KIND_APPEND: state_q <= full ? S_DONE : S_WNEW;
							KIND_INSERT: begin
								if (full || pos_x > cnt_x) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SHUP;
								end
							end
							KIND_DELETE, KIND_LOOKUP: begin
								state_q <= (cnt_q == '0) ? S_DONE : S_SRCH;
							end
							KIND_READ: state_q <= (pos_x >= cnt_x) ? S_DONE : S_RDA;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SRCH: begin
					rv_q <= issue_fwd;
					if (hit) begin
						state_q <= (op_q == KIND_DELETE) ? S_SHDN : S_DONE;
					end else if (rv_q && !issue_fwd) begin
						state_q <= S_DONE;
					end
				end
				S_SHDN: begin
					rv_q <= issue_fwd;
					if (!issue_fwd) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SHUP: begin
					rv_q <= issue_up;
					if (!issue_up) begin
						state_q <= S_WNEW;
					end
				end
				S_WNEW: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_DONE;
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= req.kind;
					key_q        <= req.record_key;
					pay_q        <= req.record_payload;
					pos_q        <= req.position;
					res_status_q <= iss_status;
					res_key_q    <= '0;
					res_pay_q    <= '0;
					res_idx_q    <= iss_idx;
					ptr_q        <= iss_ptr;
					rem_q        <= iss_rem;
					wpos_q       <= iss_wpos;
				end
			end
			S_SRCH: begin
				if (issue_fwd) begin
					ptr_q <= ptr_q + CW'(1);
					la_q  <= ptr_q[AW-1:0];
				end
				if (hit) begin
					res_idx_q <= IDX_W'(la_q);
					res_key_q <= ram_rdata.key;
					res_pay_q <= ram_rdata.payload;
				end else if (rv_q && !issue_fwd) begin
					res_status_q <= ST_NOTFOUND;
				end
			end
			S_SHDN: begin
				if (issue_fwd) begin
					ptr_q <= ptr_q + CW'(1);
					la_q  <= ptr_q[AW-1:0];
				end
			end
			S_SHUP: begin
				if (issue_up) begin
					ptr_q <= ptr_q - CW'(1);
					rem_q <= rem_q - CW'(1);
					la_q  <= ptr_q[AW-1:0];
				end
			end
			S_RDB: begin
				res_idx_q <= pos_q;
				res_key_q <= ram_rdata.key;
				res_pay_q <= ram_rdata.payload;
			end
			S_DONE: begin
				if (load_out) begin
					o_status_q <= res_status_q;
					o_key_q    <= res_key_q;
					o_pay_q    <= res_pay_q;
					o_idx_q    <= res_idx_q;
					o_cnt_q    <= IDX_W'(cnt_q);
				end
			end
			S_WNEW, S_RDA: begin
				la_q <= la_q;
			end
			default: begin
				la_q <= la_q;
			end
		endcase
	end

	assign rsp.valid       = ov_q;
	assign rsp.status      = o_status_q;
	assign rsp.out_key     = o_key_q;
	assign rsp.out_payload = o_pay_q;
	assign rsp.out_index   = o_idx_q;
	assign rsp.entry_count = o_cnt_q;

endmodule
